// File: hdl/gpgll_pkg.sv
// Package for the GPGLL sentence parser: field widths, sentence layout
// constants, character codes, result payload type and digit accumulation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpgll_pkg;

    // Field and state widths
    localparam int LAT_W   = 30;
    localparam int LON_W   = 34;
    localparam int COUNT_W = 16;
    localparam int POS_W   = 6;
    localparam int HIDX_W  = 3;
    localparam int BYTE_W  = 8;

    // Sentence layout (body positions count from the byte after the header)
    localparam int BODY_LIMIT = 60;
    localparam int STATUS_POS = 37;
    localparam int LON_START  = 13;
    localparam int LAT_LEN    = 10;
    localparam int LON_LEN    = 11;
    localparam int HDR_LEN    = 7;

    // Saturation limits
    localparam logic [LAT_W-1:0] LAT_MAX = 30'd999999999;
    localparam logic [LON_W-1:0] LON_MAX = 34'd9999999999;

    // Character codes
    localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;  // '.'
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;  // 'A'

    // Result payload; first member sits in the top bits, latitude lowest
    typedef struct packed {
        logic [COUNT_W-1:0] fix_count;
        logic [LON_W-1:0]   prev_longitude;
        logic [LAT_W-1:0]   prev_latitude;
        logic [LON_W-1:0]   longitude;
        logic [LAT_W-1:0]   latitude;
    } fix_data_t;

    localparam int DATA_W = $bits(fix_data_t);

    // Expected header character "$GPGLL," at each match index
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [HIDX_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h24;  // '$'
            3'd1:    ch = 8'h47;  // 'G'
            3'd2:    ch = 8'h50;  // 'P'
            3'd3:    ch = 8'h47;  // 'G'
            3'd4:    ch = 8'h4C;  // 'L'
            3'd5:    ch = 8'h4C;  // 'L'
            3'd6:    ch = 8'h2C;  // ','
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // acc*10 + digit, clamped to maxv. acc never exceeds maxv.
    function automatic logic [LON_W-1:0] acc_digit(input logic [LON_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] ch,
                                                   input logic [LON_W-1:0] maxv);
        logic [LON_W+3:0] sum;
        sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{LON_W{1'b0}}, ch[3:0]};
        if (sum > {4'd0, maxv}) begin
            return maxv;
        end
        return sum[LON_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/gpgll_sentence_parser.sv
// GPGLL sentence parser top level: header hunt, body capture, coordinate
// accumulation and a two-deep output buffer.
// Depends on gpgll_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   s_axis: one received ASCII character per transaction on s_tdata.
//   m_axis: one transaction per '*' that closes a captured "$GPGLL," body.
//     m_tuser  = fix_valid (status character at the status position was 'A')
//     m_tdata  = current lat/lon, previous lat/lon and fix count (x100000).
//   The result for a '*' is registered in the output register, or in the skid
//   register while m_tready holds the output. Throughput: one byte per cycle
//   while s_tready is high; all parsing for a byte is a single pass through the
//   multiply-by-ten accumulators into the state registers.
//   Stall: the result register is backed by one skid register. s_tready is
//   high whenever the skid register is empty, so bytes keep flowing while a
//   result waits; only a second pending result lowers s_tready.
//   Reset: aresetn (synchronous, active low) clears the hunt state, the
//   stored fixes, the fix count and both output buffers.
//   Bodies longer than BODY_LIMIT bytes (counting '*') are dropped silently
//   and the header hunt restarts.
module gpgll_sentence_parser
    import gpgll_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    // Input byte stream
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [BYTE_W-1:0]   s_tdata,    // [7:0] rx_byte
    // Result stream
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [DATA_W-1:0]   m_tdata,    // [29:0] latitude, [63:30] longitude,
                                            // [93:64] prev_latitude,
                                            // [127:94] prev_longitude,
                                            // [143:128] fix_count
    output logic                m_tuser     // [0] fix_valid
);

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    logic [HIDX_W-1:0]  header_index_reg, header_index_next;
    logic               capturing_reg,    capturing_next;
    logic [POS_W-1:0]   body_pos_reg,     body_pos_next;
    logic [LAT_W-1:0]   lat_acc_reg,      lat_acc_next;
    logic [LON_W-1:0]   lon_acc_reg,      lon_acc_next;
    logic               lat_stop_reg,     lat_stop_next;
    logic               lon_stop_reg,     lon_stop_next;
    logic               status_ok_reg,    status_ok_next;
    logic [LAT_W-1:0]   cur_lat_reg,      cur_lat_next;
    logic [LON_W-1:0]   cur_lon_reg,      cur_lon_next;
    logic [LAT_W-1:0]   old_lat_reg,      old_lat_next;
    logic [LON_W-1:0]   old_lon_reg,      old_lon_next;
    logic [COUNT_W-1:0] fix_count_reg,    fix_count_next;

    // Output register plus skid register
    logic               out_valid_reg,  out_valid_next;
    fix_data_t          out_data_reg,   out_data_next;
    logic               out_fix_reg,    out_fix_next;
    logic               skid_valid_reg, skid_valid_next;
    fix_data_t          skid_data_reg,  skid_data_next;
    logic               skid_fix_reg,   skid_fix_next;

    // Per-byte decode
    logic               in_xfer;
    logic               is_digit;
    logic               is_point;
    logic               in_lat_win;
    logic               in_lon_win;
    logic [LON_W-1:0]   lat_step;
    logic [LON_W-1:0]   lon_step;
    logic               res_valid;
    fix_data_t          res_data;
    logic               res_fix;

    assign in_xfer  = s_tvalid && s_tready;
    assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign is_point = (s_tdata == CHAR_POINT);

    assign in_lat_win = (body_pos_reg < POS_W'(LAT_LEN));
    assign in_lon_win = (body_pos_reg >= POS_W'(LON_START))
                     && (body_pos_reg < POS_W'(LON_START + LON_LEN));

    // Multiply-by-ten with saturation for each coordinate
    assign lat_step = acc_digit({{(LON_W-LAT_W){1'b0}}, lat_acc_reg}, s_tdata,
                                {{(LON_W-LAT_W){1'b0}}, LAT_MAX});
    assign lon_step = acc_digit(lon_acc_reg, s_tdata, LON_MAX);

    // ---------------------------------------------------------------
    // Parser next state
    // ---------------------------------------------------------------
    always_comb begin
        header_index_next = header_index_reg;
        capturing_next    = capturing_reg;
        body_pos_next     = body_pos_reg;
        lat_acc_next      = lat_acc_reg;
        lon_acc_next      = lon_acc_reg;
        lat_stop_next     = lat_stop_reg;
        lon_stop_next     = lon_stop_reg;
        status_ok_next    = status_ok_reg;
        cur_lat_next      = cur_lat_reg;
        cur_lon_next      = cur_lon_reg;
        old_lat_next      = old_lat_reg;
        old_lon_next      = old_lon_reg;
        fix_count_next    = fix_count_reg;
        res_valid         = 1'b0;
        res_fix           = status_ok_reg;

        if (in_xfer) begin
            if (!capturing_reg) begin
                // Header hunt; a mismatching byte is consumed
                if (s_tdata == hdr_char(header_index_reg)) begin
                    if (header_index_reg == HIDX_W'(HDR_LEN - 1)) begin
                        header_index_next = '0;
                        capturing_next    = 1'b1;
                        body_pos_next     = '0;
                        lat_acc_next      = '0;
                        lon_acc_next      = '0;
                        lat_stop_next     = 1'b0;
                        lon_stop_next     = 1'b0;
                        status_ok_next    = 1'b0;
                    end else begin
                        header_index_next = header_index_reg + 1'b1;
                    end
                end else begin
                    header_index_next = '0;
                end
            end else if (s_tdata == CHAR_STAR) begin
                // End of body: one result, fix updated on 'A'
                capturing_next    = 1'b0;
                header_index_next = '0;
                res_valid         = 1'b1;
                if (status_ok_reg) begin
                    old_lat_next   = cur_lat_reg;
                    old_lon_next   = cur_lon_reg;
                    cur_lat_next   = lat_acc_reg;
                    cur_lon_next   = lon_acc_reg;
                    fix_count_next = fix_count_reg + 1'b1;
                end
            end else if (body_pos_reg >= POS_W'(BODY_LIMIT - 1)) begin
                // Body too long: abandon
                capturing_next    = 1'b0;
                header_index_next = '0;
            end else begin
                if (in_lat_win && !lat_stop_reg) begin
                    if (is_digit) begin
                        lat_acc_next = lat_step[LAT_W-1:0];
                    end else if (!is_point) begin
                        lat_stop_next = 1'b1;
                    end
                end
                if (in_lon_win && !lon_stop_reg) begin
                    if (is_digit) begin
                        lon_acc_next = lon_step;
                    end else if (!is_point) begin
                        lon_stop_next = 1'b1;
                    end
                end
                if (body_pos_reg == POS_W'(STATUS_POS)) begin
                    status_ok_next = (s_tdata == CHAR_A);
                end
                body_pos_next = body_pos_reg + 1'b1;
            end
        end
    end

    always_comb begin
        res_data.latitude       = cur_lat_next;
        res_data.longitude      = cur_lon_next;
        res_data.prev_latitude  = old_lat_next;
        res_data.prev_longitude = old_lon_next;
        res_data.fix_count      = fix_count_next;
    end

    // ---------------------------------------------------------------
    // Output register and skid register
    // ---------------------------------------------------------------
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_fix_next    = out_fix_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_fix_next   = skid_fix_reg;

        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                // Skid drains first; no new result can arrive while it is full
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_fix_next    = skid_fix_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
                out_fix_next   = res_fix;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_fix_next   = res_fix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_index_reg <= '0;
            capturing_reg    <= 1'b0;
            body_pos_reg     <= '0;
            lat_acc_reg      <= '0;
            lon_acc_reg      <= '0;
            lat_stop_reg     <= 1'b0;
            lon_stop_reg     <= 1'b0;
            status_ok_reg    <= 1'b0;
            cur_lat_reg      <= '0;
            cur_lon_reg      <= '0;
            old_lat_reg      <= '0;
            old_lon_reg      <= '0;
            fix_count_reg    <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            header_index_reg <= header_index_next;
            capturing_reg    <= capturing_next;
            body_pos_reg     <= body_pos_next;
            lat_acc_reg      <= lat_acc_next;
            lon_acc_reg      <= lon_acc_next;
            lat_stop_reg     <= lat_stop_next;
            lon_stop_reg     <= lon_stop_next;
            status_ok_reg    <= status_ok_next;
            cur_lat_reg      <= cur_lat_next;
            cur_lon_reg      <= cur_lon_next;
            old_lat_reg      <= old_lat_next;
            old_lon_reg      <= old_lon_next;
            fix_count_reg    <= fix_count_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_fix_reg   <= out_fix_next;
        skid_data_reg <= skid_data_next;
        skid_fix_reg  <= skid_fix_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fix_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Skid register only fills behind a stalled output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register valid while output register empty");

    // Body position never runs past the abandon point
    a_body_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        capturing_reg |-> (body_pos_reg <= POS_W'(BODY_LIMIT - 1)))
        else $error("body position beyond limit");

    // A '*' closing a body with good status bumps the fix count by one
    a_fix_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && capturing_reg && (s_tdata == CHAR_STAR) && status_ok_reg)
        |=> (fix_count_reg == $past(fix_count_reg) + 1'b1))
        else $error("fix count not incremented on valid fix");

    // Header index stays inside the header
    a_hdr_index: assert property (@(posedge aclk) disable iff (!aresetn)
        header_index_reg <= HIDX_W'(HDR_LEN - 1))
        else $error("header index out of range");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for gpgll_sentence_parser: directed and random NMEA
// byte streams, with a built-in fix tracker that predicts every result.
// Depends on gpgll_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;
    import gpgll_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_BYTES = 1950;   // stop random stimulus after this many
    localparam int          MIN_FIXES    = 36;     // ...and once this many results are due
    localparam int          IDLE_PCT     = 15;
    localparam int          CALM_FROM    = 1200;   // byte window with no idling on either side
    localparam int          CALM_TO      = 1600;
    localparam int          HOLD_AT      = 800;    // receiver hold-off starts here
    localparam int          HOLD_CYCLES  = 500;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          MAX_REPORTS  = 10;
    localparam longint      LIMIT_NS     = 64'd2_000_000;

    localparam string       GLL_HEADER   = "$GPGLL,";
    localparam string       ODD_CHARS    = "0123456789.,-* $A";
    localparam logic [7:0]  CHAR_COMMA   = ",";
    localparam logic [7:0]  CHAR_DOLLAR  = "$";
    localparam logic [7:0]  CHAR_V       = "V";
    localparam logic [7:0]  CHAR_LOWER_A = "a";
    localparam string       SENTENCE_END = "4A\r\n";   // checksum and line end, parsed while hunting

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct {
        logic      fix_valid;
        fix_data_t data;
    } fix_report_t;

    // Tracks the parser state byte by byte and holds the fix reports still owed.
    class gll_fix_tracker;
        logic [HIDX_W-1:0]  hdr_idx;
        bit                 in_body;
        logic [POS_W-1:0]   body_pos;
        logic [LAT_W-1:0]   lat_acc;
        logic [LON_W-1:0]   lon_acc;
        bit                 lat_done;
        bit                 lon_done;
        bit                 status_ok;
        logic [LAT_W-1:0]   cur_lat;
        logic [LON_W-1:0]   cur_lon;
        logic [LAT_W-1:0]   prev_lat;
        logic [LON_W-1:0]   prev_lon;
        logic [COUNT_W-1:0] fix_cnt;
        fix_report_t        owed_fixes[$];
        int unsigned        fixes_predicted;
        int unsigned        mismatches;

        function new();
            hdr_idx         = '0;
            in_body         = 0;
            body_pos        = '0;
            lat_acc         = '0;
            lon_acc         = '0;
            lat_done        = 0;
            lon_done        = 0;
            status_ok       = 0;
            cur_lat         = '0;
            cur_lon         = '0;
            prev_lat        = '0;
            prev_lon        = '0;
            fix_cnt         = '0;
            fixes_predicted = 0;
            mismatches      = 0;
        endfunction

        // Decimal shift-in with clamp at the field's ceiling
        function logic [63:0] shift_digit(logic [63:0] acc, logic [7:0] c, logic [63:0] ceiling);
            logic [63:0] d;
            d = 64'(c - CHAR_ZERO);
            if (acc > (ceiling - d) / 10)
                return ceiling;
            return acc * 10 + d;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CHAR_ZERO && c <= CHAR_NINE;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] c);
            fix_report_t r;
            if (!in_body) begin
                // header hunt; the failing byte is consumed, match restarts at '$'
                if (c == GLL_HEADER[hdr_idx]) begin
                    if (hdr_idx == HDR_LEN - 1) begin
                        hdr_idx   = '0;
                        in_body   = 1;
                        body_pos  = '0;
                        lat_acc   = '0;
                        lon_acc   = '0;
                        lat_done  = 0;
                        lon_done  = 0;
                        status_ok = 0;
                    end else begin
                        hdr_idx++;
                    end
                end else begin
                    hdr_idx = '0;
                end
                return;
            end

            if (c == CHAR_STAR) begin
                in_body = 0;
                hdr_idx = '0;
                if (status_ok) begin
                    prev_lat = cur_lat;
                    prev_lon = cur_lon;
                    cur_lat  = lat_acc;
                    cur_lon  = lon_acc;
                    fix_cnt++;
                end
                r.fix_valid           = status_ok;
                r.data.latitude       = cur_lat;
                r.data.longitude      = cur_lon;
                r.data.prev_latitude  = prev_lat;
                r.data.prev_longitude = prev_lon;
                r.data.fix_count      = fix_cnt;
                owed_fixes.push_back(r);
                fixes_predicted++;
            end else if (body_pos >= BODY_LIMIT - 1) begin
                // body too long: dropped without a result
                in_body = 0;
                hdr_idx = '0;
            end else begin
                if (body_pos < LAT_LEN && !lat_done) begin
                    if (is_digit(c))
                        lat_acc = LAT_W'(shift_digit(64'(lat_acc), c, 64'(LAT_MAX)));
                    else if (c != CHAR_POINT)
                        lat_done = 1;
                end
                if (body_pos >= LON_START && body_pos < LON_START + LON_LEN && !lon_done) begin
                    if (is_digit(c))
                        lon_acc = LON_W'(shift_digit(64'(lon_acc), c, 64'(LON_MAX)));
                    else if (c != CHAR_POINT)
                        lon_done = 1;
                end
                if (body_pos == STATUS_POS)
                    status_ok = (c == CHAR_A);
                body_pos++;
            end
        endfunction

        function void log_mismatch(string what, fix_report_t want, logic got_valid,
                                   fix_data_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("MISMATCH at %0t: %s", $realtime, what);
                $display("  expected valid=%0d lat=%0d lon=%0d prev_lat=%0d prev_lon=%0d count=%0d",
                         want.fix_valid, want.data.latitude, want.data.longitude,
                         want.data.prev_latitude, want.data.prev_longitude,
                         want.data.fix_count);
                $display("  actual   valid=%0d lat=%0d lon=%0d prev_lat=%0d prev_lon=%0d count=%0d",
                         got_valid, got.latitude, got.longitude, got.prev_latitude,
                         got.prev_longitude, got.fix_count);
            end
        endfunction

        function void check_report(logic got_valid, logic [DATA_W-1:0] raw);
            fix_data_t   got;
            fix_report_t want;
            string       bad;
            got = raw;
            if (owed_fixes.size() == 0) begin
                want.fix_valid = 1'b0;
                want.data      = '0;
                log_mismatch("fix report with none outstanding", want, got_valid, got);
                return;
            end
            want = owed_fixes.pop_front();
            bad  = "";
            if (got_valid !== want.fix_valid)                    bad = {bad, " fix_valid"};
            if (got.latitude !== want.data.latitude)             bad = {bad, " latitude"};
            if (got.longitude !== want.data.longitude)           bad = {bad, " longitude"};
            if (got.prev_latitude !== want.data.prev_latitude)   bad = {bad, " prev_latitude"};
            if (got.prev_longitude !== want.data.prev_longitude) bad = {bad, " prev_longitude"};
            if (got.fix_count !== want.data.fix_count)           bad = {bad, " fix_count"};
            if (bad != "")
                log_mismatch({"field(s)", bad}, want, got_valid, got);
        endfunction
    endclass

    // Clock, reset and DUT ports
    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;     // [7:0] rx_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;           // [29:0] lat, [63:30] lon, [93:64] prev_lat,
                                          // [127:94] prev_lon, [143:128] fix_count
    logic              m_tuser;           // [0] fix_valid

    gll_fix_tracker fixes = new();
    int unsigned    bytes_sent = 0;
    bit             calm       = 0;       // no idling on either side while set
    bit             hold_req   = 0;       // asks the receiver for one long hold-off

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    gpgll_sentence_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One byte transaction; random idle cycles ahead of it outside the calm window.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        calm = (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fixes.note_byte(b);
        bytes_sent++;
        if (bytes_sent == HOLD_AT)
            hold_req = 1'b1;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    // Header, fields padded/cut so the status lands on its slot, tail filler, '*', checksum and line end
    function automatic byte_q_t gll_sentence(string fields, logic [7:0] status,
                                             int unsigned tail);
        byte_q_t q;
        for (int i = 0; i < GLL_HEADER.len(); i++)
            q.push_back(GLL_HEADER[i]);
        for (int i = 0; i < STATUS_POS; i++)
            q.push_back(i < fields.len() ? fields[i] : CHAR_COMMA);
        q.push_back(status);
        repeat (tail) q.push_back(CHAR_COMMA);
        q.push_back(CHAR_STAR);
        for (int i = 0; i < SENTENCE_END.len(); i++)
            q.push_back(SENTENCE_END[i]);
        return q;
    endfunction

    // ddmm.mmmmm,H,dddmm.mmmmm,H,hhmmss.ss, -- exactly fills the slots before status
    function automatic string fix_fields();
        return $sformatf("%04d.%05d,%s,%05d.%05d,%s,%06d.%02d,",
                         $urandom_range(0, 9999), $urandom_range(0, 99999),
                         $urandom_range(0, 1) ? "N" : "S",
                         $urandom_range(0, 99999), $urandom_range(0, 99999),
                         $urandom_range(0, 1) ? "E" : "W",
                         $urandom_range(0, 999999), $urandom_range(0, 99));
    endfunction

    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(0, 255));
        return ODD_CHARS[$urandom_range(0, ODD_CHARS.len() - 1)];
    endfunction

    // Mostly clean sentences with random content; the rest corrupted or plain noise.
    task automatic send_random_sentence();
        byte_q_t     q;
        int unsigned kind;
        int unsigned tail;
        int unsigned idx;
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 4))
                send_byte($urandom_range(0, 3) == 0 ? CHAR_DOLLAR : 8'($urandom_range(0, 255)));
        kind = $urandom_range(0, 99);
        tail = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : $urandom_range(0, 2);
        q = gll_sentence(fix_fields(), $urandom_range(0, 3) != 0 ? CHAR_A : CHAR_V, tail);
        if (kind < 55) begin
            // clean
        end else if (kind < 72) begin
            repeat ($urandom_range(1, 3)) begin
                idx    = $urandom_range(HDR_LEN, q.size() - 6);
                q[idx] = random_char();
            end
        end else if (kind < 82) begin
            // early '*': short body
            q[HDR_LEN + $urandom_range(0, STATUS_POS)] = CHAR_STAR;
        end else if (kind < 92) begin
            q[$urandom_range(0, HDR_LEN - 1)] = random_char();
        end else begin
            q.delete();
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
        end
        send_bytes(q);
    endtask

    // Result side: check each accepted fix report, then pick m_tready for the next cycle.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready)
                fixes.check_report(m_tuser, m_tdata);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;   // long back-pressure: parser must fill and stall
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Noise while hunting, including a stray '$' and '*'
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_DOLLAR);
        send_byte(CHAR_STAR);
        // Valid fix, then an invalid one, then a second valid one (moves current to previous)
        send_bytes(gll_sentence("4916.45000,N,12311.12000,W,225444.00,", CHAR_A, 2));
        send_bytes(gll_sentence("0000.00001,S,00000.00002,E,000000.00,", CHAR_V, 2));
        send_bytes(gll_sentence("5107.01234,N,00012.34567,W,120000.00,", CHAR_A, 0));
        // Empty body and a body cut before the status
        send_text("$GPGLL,*");
        send_text("$GPGLL,4916.45,N*");
        // Header mismatches: the failing byte is consumed, so the inner "$GPGLL," is lost
        send_text("$GPGLX$GP$GPGLL,12*");
        // Saturating digits in both windows
        send_bytes(gll_sentence("9999999999,N,99999999999,E,000000.00,", CHAR_A, 1));
        // Repeated points keep accumulating; space and sign stop a field
        send_bytes(gll_sentence("1.2.3.4.5.,S,0012 3.456,W,1-2-3,", CHAR_A, 0));
        send_bytes(gll_sentence("-123.45678,N,.9.9.9.9.9.,E,", CHAR_A, 0));
        // Empty coordinate fields
        send_bytes(gll_sentence(",,,,,,,", CHAR_A, 0));
        // '*' sitting on the status slot, and a lowercase status
        send_bytes(gll_sentence("4916.45000,N,12311.12000,W,225444.00,", CHAR_STAR, 0));
        send_bytes(gll_sentence("4916.45000,N,12311.12000,W,225444.00,", CHAR_LOWER_A, 0));
        // Longest body that still reports, then one byte too long (dropped)
        send_bytes(gll_sentence("3000.00000,N,04000.00000,E,010203.04,", CHAR_A, 21));
        send_bytes(gll_sentence("3100.00000,N,04100.00000,E,010203.04,", CHAR_A, 22));

        while (bytes_sent < RANDOM_BYTES || fixes.fixes_predicted < MIN_FIXES)
            send_random_sentence();
        s_tvalid <= 1'b0;

        while (fixes.owed_fixes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fixes.mismatches == 0 && fixes.owed_fixes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
